FILE: sv/multilevel_priority_queue_assert.svh
// ---------------------------------------------------------------------------
// multilevel_priority_queue_assert.svh
// Assertion macros used by the priority queue controller.
// ---------------------------------------------------------------------------
`ifndef MULTILEVEL_PRIORITY_QUEUE_ASSERT_SVH
`define MULTILEVEL_PRIORITY_QUEUE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define MPQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mpq assertion failed");
// next-cycle implication
`define MPQ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mpq assertion failed");
`else
`define MPQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define MPQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: sv/mpq_pkg.sv
// ---------------------------------------------------------------------------
// mpq_pkg
// Shared codes, defaults and the controller/datapath interface types.
// ---------------------------------------------------------------------------
package mpq_pkg;

  localparam int NUM_NODES_DEF  = 64;
  localparam int NUM_LEVELS_DEF = 8;

  localparam int MODE_W = 3;
  localparam int NODE_W = 6;
  localparam int PRIO_W = 3;
  localparam int STAT_W = 2;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_APPEND  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DEQUEUE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CHANGE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_QUEUED  = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_QUE = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic              load;
    logic              read;
    logic              unlink;
    logic              link;
    logic              push;
    logic              take_level;
    logic              finish;
    logic [STAT_W-1:0] code;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              node_ok;
    logic              queued;
    logic              found;
  } stat_t;

endpackage

FILE: sv/multilevel_priority_queue.sv
// ---------------------------------------------------------------------------
// multilevel_priority_queue
// Per-level doubly linked lists over a shared pool of node slots.
// ---------------------------------------------------------------------------
// After its accepting edge, a word runs through a sequence of steps until its
// result is loaded into the output register. It reads the node's links,
// unlinks the node when it is queued or dequeued, links it at its target
// level, and loads the result register. Rejected words and words with an
// unused mode skip unlinking and linking. Dequeue and remove only unlink; an
// append or push of an unqueued node only links. A move or push of a queued
// node both unlinks and links. After each result is loaded the block returns
// to idle, where it accepts the next word. That result may still wait in the
// output register. A stalled result delays only the load of the next result.
module multilevel_priority_queue #(
  parameter int NUM_NODES  = mpq_pkg::NUM_NODES_DEF,
  parameter int NUM_LEVELS = mpq_pkg::NUM_LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mpq_pkg::MODE_W-1:0] mode,
  input  logic [mpq_pkg::NODE_W-1:0] node_id,
  input  logic [mpq_pkg::PRIO_W-1:0] priority_req,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [mpq_pkg::NODE_W-1:0] result_node,
  output logic [mpq_pkg::PRIO_W-1:0] result_priority,
  output logic [mpq_pkg::STAT_W-1:0] status,
  output logic                       queue_empty
);

  mpq_pkg::cmd_t  cmd;
  mpq_pkg::stat_t stat;

  // sequencer
  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // lists and result word
  mpq_dp #(
    .NUM_NODES  (NUM_NODES),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .mode            (mode),
    .node_id         (node_id),
    .priority_req    (priority_req),
    .cmd             (cmd),
    .stat            (stat),
    .result_node     (result_node),
    .result_priority (result_priority),
    .status          (status),
    .queue_empty     (queue_empty)
  );

endmodule

FILE: sv/mpq_dp.sv
// ---------------------------------------------------------------------------
// mpq_dp
// Link memories, per-level head/tail/count registers and the result word.
// ---------------------------------------------------------------------------
module mpq_dp #(
  parameter int NUM_NODES  = mpq_pkg::NUM_NODES_DEF,
  parameter int NUM_LEVELS = mpq_pkg::NUM_LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mpq_pkg::MODE_W-1:0] mode,
  input  logic [mpq_pkg::NODE_W-1:0] node_id,
  input  logic [mpq_pkg::PRIO_W-1:0] priority_req,
  input  mpq_pkg::cmd_t              cmd,
  output mpq_pkg::stat_t             stat,
  output logic [mpq_pkg::NODE_W-1:0] result_node,
  output logic [mpq_pkg::PRIO_W-1:0] result_priority,
  output logic [mpq_pkg::STAT_W-1:0] status,
  output logic                       queue_empty
);

  localparam int NW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int CW = $clog2(NUM_NODES + 1);

  // latched item
  logic [mpq_pkg::MODE_W-1:0] mode_q;
  logic [mpq_pkg::NODE_W-1:0] node_q;
  logic [LW-1:0]              lv_q;
  logic [NW-1:0]              cur;
  logic [mpq_pkg::NODE_W-1:0] res_node;
  logic [mpq_pkg::PRIO_W-1:0] res_lv;
  logic [mpq_pkg::STAT_W-1:0] res_code;

  // link memories
  logic [NW-1:0] next_mem  [NUM_NODES];
  logic [NW-1:0] prev_mem  [NUM_NODES];
  logic [LW-1:0] level_mem [NUM_NODES];
  logic [NW-1:0] next_rd;
  logic [NW-1:0] prev_rd;
  logic [LW-1:0] level_rd;

  // level registers and queued flags
  logic [NW-1:0]        level_head  [NUM_LEVELS];
  logic [NW-1:0]        level_tail  [NUM_LEVELS];
  logic [CW-1:0]        level_count [NUM_LEVELS];
  logic [NUM_NODES-1:0] node_queued;

  logic [LW-1:0]         lv_sat;
  logic [NW-1:0]         n_idx;
  logic                  node_ok;
  logic [NUM_LEVELS-1:0] nonempty;
  logic [LW-1:0]         top;
  logic [LW-1:0]         lvl_addr;
  logic [NW-1:0]         head_sel;
  logic [NW-1:0]         tail_sel;
  logic [CW-1:0]         count_sel;
  logic [NW-1:0]         rd_addr;
  logic                  first;
  logic                  last;
  logic                  lvl_empty;
  logic                  nx_we;
  logic [NW-1:0]         nx_wa;
  logic [NW-1:0]         nx_wd;
  logic                  pv_we;
  logic [NW-1:0]         pv_wa;
  logic [NW-1:0]         pv_wd;

  // saturate the requested level
  assign lv_sat  = (32'(priority_req) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1)
                                                     : LW'(priority_req);
  assign n_idx   = NW'(node_q);
  assign node_ok = 32'(node_q) < NUM_NODES;

  // find the highest non-empty level
  always_comb begin
    top = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      nonempty[i] = level_count[i] != '0;
      if (nonempty[i]) top = LW'(i);
    end
  end

  // one level address per cycle
  always_comb begin
    if (cmd.read) lvl_addr = top;
    else if (cmd.unlink) lvl_addr = level_rd;
    else lvl_addr = lv_q;
  end

  assign head_sel  = level_head[lvl_addr];
  assign tail_sel  = level_tail[lvl_addr];
  assign count_sel = level_count[lvl_addr];
  assign rd_addr   = (mode_q == mpq_pkg::MODE_DEQUEUE) ? head_sel : n_idx;
  assign first     = head_sel == cur;
  assign last      = tail_sel == cur;
  assign lvl_empty = count_sel == '0;

  assign stat.mode    = mode_q;
  assign stat.node_ok = node_ok;
  assign stat.queued  = node_ok && node_queued[n_idx];
  assign stat.found   = |nonempty;

  // link write ports
  always_comb begin
    nx_we = 1'b0;
    nx_wa = cur;
    nx_wd = cur;
    pv_we = 1'b0;
    pv_wa = cur;
    pv_wd = cur;
    if (cmd.unlink) begin
      nx_we = !first;
      nx_wa = prev_rd;
      nx_wd = next_rd;
      pv_we = !last;
      pv_wa = next_rd;
      pv_wd = prev_rd;
    end else if (cmd.link && !lvl_empty) begin
      nx_we = 1'b1;
      pv_we = 1'b1;
      if (cmd.push) begin
        pv_wa = head_sel;
        nx_wd = head_sel;
      end else begin
        nx_wa = tail_sel;
        pv_wd = tail_sel;
      end
    end
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (cmd.link) level_mem[cur] <= lv_q;
    if (cmd.read) begin
      next_rd  <= next_mem[rd_addr];
      prev_rd  <= prev_mem[rd_addr];
      level_rd <= level_mem[rd_addr];
    end
  end

  // counts and queued flags
  always_ff @(posedge clk) begin
    if (rst) begin
      node_queued <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) level_count[i] <= '0;
    end else if (cmd.unlink) begin
      node_queued[cur]      <= 1'b0;
      level_count[lvl_addr] <= count_sel - CW'(1);
    end else if (cmd.link) begin
      node_queued[cur]      <= 1'b1;
      level_count[lvl_addr] <= count_sel + CW'(1);
    end
  end

  // head and tail pointers
  always_ff @(posedge clk) begin
    if (cmd.unlink) begin
      if (first) level_head[lvl_addr] <= next_rd;
      if (last) level_tail[lvl_addr] <= prev_rd;
    end else if (cmd.link) begin
      if (cmd.push) begin
        level_head[lvl_addr] <= cur;
        if (lvl_empty) level_tail[lvl_addr] <= cur;
      end else begin
        level_tail[lvl_addr] <= cur;
        if (lvl_empty) level_head[lvl_addr] <= cur;
      end
    end
  end

  // item latch and result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q   <= mode;
      node_q   <= node_id;
      lv_q     <= lv_sat;
      res_node <= node_id;
      res_lv   <= mpq_pkg::PRIO_W'(lv_sat);
    end
    if (cmd.read) begin
      cur      <= rd_addr;
      res_code <= cmd.code;
      if (mode_q == mpq_pkg::MODE_DEQUEUE) begin
        if (|nonempty) begin
          res_node <= mpq_pkg::NODE_W'(head_sel);
          res_lv   <= mpq_pkg::PRIO_W'(top);
        end else begin
          res_node <= '0;
          res_lv   <= '0;
        end
      end
    end
    if (cmd.unlink && cmd.take_level) res_lv <= mpq_pkg::PRIO_W'(level_rd);
    if (cmd.finish) begin
      result_node     <= res_node;
      result_priority <= res_lv;
      status          <= res_code;
      queue_empty     <= ~|nonempty;
    end
  end

endmodule

FILE: sv/mpq_ctrl.sv
// ---------------------------------------------------------------------------
// mpq_ctrl
// Operation sequencer: latch, read links, unlink, relink, deliver the word.
// ---------------------------------------------------------------------------
`include "multilevel_priority_queue_assert.svh"

module mpq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  mpq_pkg::stat_t stat,
  output mpq_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_UNLINK = 3'd2;
  localparam logic [2:0] S_LINK   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       do_link;
  logic       do_link_next;

  assign in_stall = state != S_IDLE;

  // sequence one operation
  always_comb begin
    state_next   = state;
    do_link_next = do_link;
    cmd          = '0;
    cmd.code     = mpq_pkg::ST_DONE;
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) state_next = S_READ;
      end
      S_READ: begin
        cmd.read     = 1'b1;
        do_link_next = 1'b0;
        state_next   = S_DONE;
        unique case (stat.mode) inside
          mpq_pkg::MODE_DEQUEUE: begin
            if (stat.found) state_next = S_UNLINK;
            else cmd.code = mpq_pkg::ST_EMPTY;
          end
          mpq_pkg::MODE_APPEND: begin
            if (!stat.node_ok) cmd.code = mpq_pkg::ST_NOT_QUE;
            else if (stat.queued) cmd.code = mpq_pkg::ST_QUEUED;
            else state_next = S_LINK;
          end
          mpq_pkg::MODE_CHANGE, mpq_pkg::MODE_PUSH: begin
            if (!stat.node_ok) cmd.code = mpq_pkg::ST_NOT_QUE;
            else if (stat.queued) begin
              state_next   = S_UNLINK;
              do_link_next = 1'b1;
            end else state_next = S_LINK;
          end
          mpq_pkg::MODE_REMOVE: begin
            if (!stat.node_ok || !stat.queued) cmd.code = mpq_pkg::ST_NOT_QUE;
            else state_next = S_UNLINK;
          end
          default: ;
        endcase
      end
      S_UNLINK: begin
        cmd.unlink     = 1'b1;
        cmd.take_level = stat.mode == mpq_pkg::MODE_REMOVE;
        state_next     = do_link ? S_LINK : S_DONE;
      end
      S_LINK: begin
        cmd.link   = 1'b1;
        cmd.push   = stat.mode == mpq_pkg::MODE_PUSH;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // hold state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      do_link   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      do_link <= do_link_next;
      if (cmd.finish) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  `MPQ_ASSERT_NXT(a_finish_valid, clk, rst, cmd.finish, out_valid)
  `MPQ_ASSERT_NXT(a_accept_read, clk, rst, in_valid && !in_stall, state == S_READ)
  `MPQ_ASSERT_IMP(a_link_after, clk, rst, cmd.link, !cmd.unlink && !cmd.read)

endmodule
